FILE: sv/arsm_pkg.sv
package arsm_pkg;

    // default widths
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // configuration register file
    localparam int CFG_WIDTH  = 16;
    localparam int LIM_WIDTH  = 8;
    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;

    localparam logic [2:0] REG_POWER_MIN      = 3'd0;
    localparam logic [2:0] REG_POWER_MAX      = 3'd1;
    localparam logic [2:0] REG_POWER_SAFE     = 3'd2;
    localparam logic [2:0] REG_MOTOR_VOLT_MAX = 3'd3;
    localparam logic [2:0] REG_MOTOR_CUR_MAX  = 3'd4;
    localparam logic [2:0] REG_CONSEC_LIMIT   = 3'd5;
    localparam logic [2:0] REG_TIMEOUT_LIMIT  = 3'd6;

    localparam logic [CFG_WIDTH-1:0] RST_POWER_MIN      = 16'd6000;
    localparam logic [CFG_WIDTH-1:0] RST_POWER_MAX      = 16'd18000;
    localparam logic [CFG_WIDTH-1:0] RST_POWER_SAFE     = 16'd12000;
    localparam logic [CFG_WIDTH-1:0] RST_MOTOR_VOLT_MAX = 16'd20000;
    localparam logic [CFG_WIDTH-1:0] RST_MOTOR_CUR_MAX  = 16'd30000;
    localparam logic [LIM_WIDTH-1:0] RST_CONSEC_LIMIT   = 8'd3;
    localparam logic [CFG_WIDTH-1:0] RST_TIMEOUT_LIMIT  = 16'd10;

    // request kinds
    localparam logic [1:0] REQ_POWER = 2'd0;
    localparam logic [1:0] REQ_MOTOR = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_SOURCE  = 3'd3;
    localparam logic [2:0] ST_SAFE    = 3'd4;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] power_min;
        logic [CFG_WIDTH-1:0] power_max;
        logic [CFG_WIDTH-1:0] power_safe;
        logic [CFG_WIDTH-1:0] motor_volt_max;
        logic [CFG_WIDTH-1:0] motor_cur_max;
        logic [LIM_WIDTH-1:0] consec_limit;
        logic [CFG_WIDTH-1:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic       clear_timeout;
        logic       safe_state;
        logic [2:0] status;
    } res_flags_t;

endpackage

FILE: sv/arsm_cfg.sv
module arsm_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [arsm_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [arsm_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [arsm_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                             pready,
    output arsm_pkg::cfg_t                   cfg
);

    arsm_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.power_min      <= arsm_pkg::RST_POWER_MIN;
            cfg_reg.power_max      <= arsm_pkg::RST_POWER_MAX;
            cfg_reg.power_safe     <= arsm_pkg::RST_POWER_SAFE;
            cfg_reg.motor_volt_max <= arsm_pkg::RST_MOTOR_VOLT_MAX;
            cfg_reg.motor_cur_max  <= arsm_pkg::RST_MOTOR_CUR_MAX;
            cfg_reg.consec_limit   <= arsm_pkg::RST_CONSEC_LIMIT;
            cfg_reg.timeout_limit  <= arsm_pkg::RST_TIMEOUT_LIMIT;
        end else if (wr_en) begin
            case (reg_idx)
                arsm_pkg::REG_POWER_MIN:      cfg_reg.power_min      <= pwdata[15:0];
                arsm_pkg::REG_POWER_MAX:      cfg_reg.power_max      <= pwdata[15:0];
                arsm_pkg::REG_POWER_SAFE:     cfg_reg.power_safe     <= pwdata[15:0];
                arsm_pkg::REG_MOTOR_VOLT_MAX: cfg_reg.motor_volt_max <= pwdata[15:0];
                arsm_pkg::REG_MOTOR_CUR_MAX:  cfg_reg.motor_cur_max  <= pwdata[15:0];
                arsm_pkg::REG_CONSEC_LIMIT:   cfg_reg.consec_limit   <= pwdata[7:0];
                arsm_pkg::REG_TIMEOUT_LIMIT:  cfg_reg.timeout_limit  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            arsm_pkg::REG_POWER_MIN:      prdata = {16'd0, cfg_reg.power_min};
            arsm_pkg::REG_POWER_MAX:      prdata = {16'd0, cfg_reg.power_max};
            arsm_pkg::REG_POWER_SAFE:     prdata = {16'd0, cfg_reg.power_safe};
            arsm_pkg::REG_MOTOR_VOLT_MAX: prdata = {16'd0, cfg_reg.motor_volt_max};
            arsm_pkg::REG_MOTOR_CUR_MAX:  prdata = {16'd0, cfg_reg.motor_cur_max};
            arsm_pkg::REG_CONSEC_LIMIT:   prdata = {24'd0, cfg_reg.consec_limit};
            arsm_pkg::REG_TIMEOUT_LIMIT:  prdata = {16'd0, cfg_reg.timeout_limit};
            default:                      prdata = '0;
        endcase
    end

endmodule

FILE: sv/arsm_eval.sv
module arsm_eval #(
    parameter int COUNT_WIDTH  = arsm_pkg::COUNT_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = arsm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic [1:0]                   req_type,
    input  logic [3:0][SAMPLE_WIDTH-1:0] ch,
    input  logic                         timeout_flag,
    input  logic                         source_ok,
    input  arsm_pkg::cfg_t               cfg,
    input  logic [COUNT_WIDTH-1:0]       tmo_cnt,
    input  logic [COUNT_WIDTH-1:0]       rng_cnt,
    input  logic [COUNT_WIDTH-1:0]       con_cnt,
    input  logic                         safe_latch,
    output logic [3:0][SAMPLE_WIDTH-1:0] ch_out,
    output arsm_pkg::res_flags_t         flags,
    output logic [COUNT_WIDTH-1:0]       tmo_cnt_next,
    output logic [COUNT_WIDTH-1:0]       rng_cnt_next,
    output logic [COUNT_WIDTH-1:0]       con_cnt_next,
    output logic                         safe_latch_next
);

    localparam int CMP_W = (SAMPLE_WIDTH > arsm_pkg::CFG_WIDTH) ? SAMPLE_WIDTH
                                                                 : arsm_pkg::CFG_WIDTH;
    localparam int LIM_W = (COUNT_WIDTH > arsm_pkg::CFG_WIDTH) ? COUNT_WIDTH
                                                                : arsm_pkg::CFG_WIDTH;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    logic [CMP_W-1:0] lo_v;
    logic [CMP_W-1:0] hi_v;
    logic [CMP_W-1:0] smp_v;
    logic             bad;
    logic             group;

    // channels are walked in order; each good one restarts the consecutive run
    always_comb begin
        ch_out          = '0;
        flags           = '0;
        flags.status    = arsm_pkg::ST_OK;
        tmo_cnt_next    = tmo_cnt;
        rng_cnt_next    = rng_cnt;
        con_cnt_next    = con_cnt;
        safe_latch_next = safe_latch;
        bad             = 1'b0;
        group           = 1'b0;
        lo_v            = '0;
        hi_v            = '0;
        smp_v           = '0;

        case (req_type)
            arsm_pkg::REQ_POWER: begin
                group = 1'b1;
                if (timeout_flag) begin
                    tmo_cnt_next = sat_inc(tmo_cnt);
                    con_cnt_next = sat_inc(con_cnt);
                    for (int i = 0; i < 3; i++)
                        ch_out[i] = SAMPLE_WIDTH'(cfg.power_safe);
                    flags.status = arsm_pkg::ST_TIMEOUT;
                end else if (!source_ok) begin
                    for (int i = 0; i < 3; i++)
                        ch_out[i] = SAMPLE_WIDTH'(cfg.power_safe);
                    flags.status = arsm_pkg::ST_SOURCE;
                end else begin
                    lo_v = CMP_W'(cfg.power_min);
                    hi_v = CMP_W'(cfg.power_max);
                    for (int i = 0; i < 3; i++) begin
                        smp_v = CMP_W'(ch[i]);
                        if (smp_v < lo_v || smp_v > hi_v) begin
                            rng_cnt_next = sat_inc(rng_cnt_next);
                            con_cnt_next = sat_inc(con_cnt_next);
                            ch_out[i]    = SAMPLE_WIDTH'(cfg.power_safe);
                            bad          = 1'b1;
                        end else begin
                            con_cnt_next = '0;
                            ch_out[i]    = ch[i];
                        end
                    end
                    flags.status = bad ? arsm_pkg::ST_RANGE : arsm_pkg::ST_OK;
                end
            end
            arsm_pkg::REQ_MOTOR: begin
                group = 1'b1;
                if (source_ok) begin
                    for (int i = 0; i < 4; i++) begin
                        hi_v  = (i < 2) ? CMP_W'(cfg.motor_volt_max)
                                        : CMP_W'(cfg.motor_cur_max);
                        smp_v = CMP_W'(ch[i]);
                        if (smp_v > hi_v) begin
                            rng_cnt_next = sat_inc(rng_cnt_next);
                            con_cnt_next = sat_inc(con_cnt_next);
                            ch_out[i]    = '0;
                            bad          = 1'b1;
                        end else begin
                            con_cnt_next = '0;
                            ch_out[i]    = ch[i];
                        end
                    end
                    flags.status = bad ? arsm_pkg::ST_RANGE : arsm_pkg::ST_OK;
                end else begin
                    flags.status = arsm_pkg::ST_SOURCE;
                end
            end
            arsm_pkg::REQ_CLEAR: begin
                tmo_cnt_next        = '0;
                rng_cnt_next        = '0;
                con_cnt_next        = '0;
                safe_latch_next     = 1'b0;
                flags.clear_timeout = 1'b1;
            end
            default: ;
        endcase

        if (group) begin
            if (LIM_W'(con_cnt_next) >= LIM_W'(cfg.consec_limit) ||
                LIM_W'(tmo_cnt_next) >= LIM_W'(cfg.timeout_limit))
                safe_latch_next = 1'b1;
            if (safe_latch_next)
                flags.status = arsm_pkg::ST_SAFE;
        end
        flags.safe_state = safe_latch_next;
    end

endmodule

FILE: sv/adc_range_safety_monitor_unit.sv
// channel  | dir | tdata (low bit up)                                 | tuser (low bit up)
// s_       | in  | ch0, ch1, ch2, ch3                                 | req_type[1:0],
//          |     |                                                    | timeout_flag, source_ok
// m_       | out | ch0_out..ch3_out, timeout_total, range_errors,     | status[2:0],
//          |     | consec_errors                                      | safe_state, clear_timeout
// apb      | in  | 32-bit register writes and reads, register i at byte address 4*i
//
// An input beat passes the input register, then the result register, to reach its
// result beat. One beat per cycle sustained while m_tready stays high; the counters
// and the safe latch are updated in the same cycle that the result register loads,
// so the next beat sees them at once.
// Reset (aresetn low, synchronous): both valid flags, counters and safe latch clear;
// configuration registers return to their default limits.
// Stalls: with m_tready low the result waits in its register while one more beat
// can sit in the input register; s_tready drops only when both are full.
module adc_range_safety_monitor_unit #(
    parameter int COUNT_WIDTH  = arsm_pkg::COUNT_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = arsm_pkg::SAMPLE_WIDTH_DEF,
    localparam int IN_DATA_W   = ((4 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_RAW_W   = 4 * SAMPLE_WIDTH + 3 * COUNT_WIDTH,
    localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // ch0, ch1, ch2, ch3 from bit 0 up, zero padded to bytes
    input  logic [IN_DATA_W-1:0]            s_tdata,
    // req_type[1:0], timeout_flag, source_ok
    input  logic [3:0]                      s_tuser,
    // result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // ch0_out, ch1_out, ch2_out, ch3_out, timeout_total, range_errors, consec_errors
    output logic [OUT_DATA_W-1:0]           m_tdata,
    // status[2:0], safe_state, clear_timeout
    output logic [4:0]                      m_tuser,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [arsm_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [arsm_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [arsm_pkg::DATA_WIDTH-1:0] prdata,
    output logic                            pready
);

    localparam int CNT_LSB    = 4 * SAMPLE_WIDTH;

    arsm_pkg::cfg_t       cfg;
    arsm_pkg::res_flags_t flags;

    // input stage
    logic                   in_valid_reg;
    logic [IN_DATA_W-1:0]   in_data_reg;
    logic [3:0]             in_user_reg;

    // block state
    logic [COUNT_WIDTH-1:0] tmo_cnt_reg, tmo_cnt_next;
    logic [COUNT_WIDTH-1:0] rng_cnt_reg, rng_cnt_next;
    logic [COUNT_WIDTH-1:0] con_cnt_reg, con_cnt_next;
    logic                   safe_latch_reg, safe_latch_next;

    // result stage
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;
    logic [4:0]             out_user_reg;

    logic [3:0][SAMPLE_WIDTH-1:0] ch_in;
    logic [3:0][SAMPLE_WIDTH-1:0] ch_out;
    logic                         advance;

    // the held beat moves on whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        for (int i = 0; i < 4; i++)
            ch_in[i] = in_data_reg[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    end

    arsm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    arsm_eval #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_eval (
        .req_type        (in_user_reg[1:0]),
        .ch              (ch_in),
        .timeout_flag    (in_user_reg[2]),
        .source_ok       (in_user_reg[3]),
        .cfg             (cfg),
        .tmo_cnt         (tmo_cnt_reg),
        .rng_cnt         (rng_cnt_reg),
        .con_cnt         (con_cnt_reg),
        .safe_latch      (safe_latch_reg),
        .ch_out          (ch_out),
        .flags           (flags),
        .tmo_cnt_next    (tmo_cnt_next),
        .rng_cnt_next    (rng_cnt_next),
        .con_cnt_next    (con_cnt_next),
        .safe_latch_next (safe_latch_next)
    );

    // pack the result beat; counters shown are the values after this beat
    always_comb begin
        out_data_next = '0;
        for (int i = 0; i < 4; i++)
            out_data_next[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = ch_out[i];
        out_data_next[CNT_LSB +: COUNT_WIDTH]                   = tmo_cnt_next;
        out_data_next[CNT_LSB + COUNT_WIDTH +: COUNT_WIDTH]     = rng_cnt_next;
        out_data_next[CNT_LSB + 2 * COUNT_WIDTH +: COUNT_WIDTH] = con_cnt_next;
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            tmo_cnt_reg    <= '0;
            rng_cnt_reg    <= '0;
            con_cnt_reg    <= '0;
            safe_latch_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance) begin
                tmo_cnt_reg    <= tmo_cnt_next;
                rng_cnt_reg    <= rng_cnt_next;
                con_cnt_reg    <= con_cnt_next;
                safe_latch_reg <= safe_latch_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
            out_user_reg <= flags;
        end
    end

    // a clear beat always reports zeroed counters and an open latch
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[4]) |->
        (m_tdata[CNT_LSB +: COUNT_WIDTH] == '0) &&
        (m_tdata[CNT_LSB + COUNT_WIDTH +: COUNT_WIDTH] == '0) &&
        (m_tdata[CNT_LSB + 2 * COUNT_WIDTH +: COUNT_WIDTH] == '0) && !m_tuser[3])
        else $error("clear beat with nonzero diagnostics");

    // only a clear request may drop the safe latch
    a_safe_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && safe_latch_reg && (in_user_reg[1:0] != arsm_pkg::REQ_CLEAR))
        |=> safe_latch_reg)
        else $error("safe latch dropped without clear");

    // a held beat stays put until the result register takes it
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("input beat lost while result stage busy");

    // safe status implies the latch is shown set
    a_safe_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:0] == arsm_pkg::ST_SAFE)) |-> m_tuser[3])
        else $error("safe status without safe state");

    // state moves only with a beat through the result stage
    a_state_still: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(tmo_cnt_reg) && $stable(rng_cnt_reg) &&
                      $stable(con_cnt_reg) && $stable(safe_latch_reg)))
        else $error("diagnostic state changed without a beat");

endmodule
